// ===== hdl/bdll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdll_pkg
// Operation and status codes plus the controller/datapath command and status
// structs shared by the linked list engine.
// ----------------------------------------------------------------------------
package bdll_pkg;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AFTER = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_BACK  = 3'd4,
        OP_REM_VALUE = 3'd5,
        OP_FIND      = 3'd6,
        OP_CLEAR     = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Micro-operations the controller issues to the datapath.
    typedef enum logic [3:0] {
        UC_NOP,
        UC_LOAD,        // capture the input item
        UC_SRCH_START,  // point the walker at the head
        UC_SRCH_STEP,   // compare the fetched node and advance
        UC_RD_NEXT,     // fetch next link of the position node
        UC_RD_PREV,     // fetch prev link of the position node
        UC_INS_FRONT,
        UC_INS_BACK,
        UC_INS_AFTER,
        UC_UNLINK,      // remove the node at the position register
        UC_POS_HEAD,
        UC_POS_TAIL,
        UC_CLEAR_STEP
    } t_ucmd;

    typedef struct packed {
        t_ucmd cmd;
    } t_ctl;

    typedef struct packed {
        logic full;
        logic empty;
        logic srch_done;
        logic srch_hit;
        logic clear_done;
        logic one_left;
    } t_sts;

endpackage

// ===== hdl/bounded_doubly_linked_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list_engine
// Doubly linked list of signed 32-bit values in a pool of CAPACITY nodes.
// ----------------------------------------------------------------------------
// One item is handled at a time. Find, remove-by-value and insert-after walk
// the list from the head node by node (registered pool read, then compare).
// Clear, and the start after reset, sweep the free stack one entry per cycle,
// during which no item is accepted. The result sits in an output register; a
// new item is taken only once that register is empty or its result is being
// transferred.
module bounded_doubly_linked_list_engine
    import bdll_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_item_value,
    input  logic signed [31:0] i_anchor_key,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic [6:0]         o_length
);
    localparam int CW = $clog2(CAPACITY + 1);

    t_ctl          w_ctl;
    t_sts          w_sts;
    logic [CW-1:0] w_count;
    logic          w_res_load;
    logic [1:0]    w_res_status;
    logic          w_res_found;
    logic          r_valid;
    logic [1:0]    r_status;
    logic          r_found;
    logic [6:0]    r_length;
    logic [CW+6:0] w_count_ext;

    assign w_count_ext = {7'd0, w_count};

    bdll_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl),
        .o_res_load  (w_res_load),
        .o_res_status(w_res_status),
        .o_res_found (w_res_found),
        .i_res_busy  (r_valid && i_stall)
    );

    bdll_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_operation  (i_operation),
        .i_item_value (i_item_value),
        .i_anchor_key (i_anchor_key),
        .o_sts        (w_sts),
        .o_count      (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_res_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_status <= w_res_status;
            r_found  <= w_res_found;
            r_length <= w_count_ext[6:0];
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_found  = r_found;
    assign o_length = r_length;

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_valid && i_stall) |=> (r_valid && $stable(r_status) && $stable(r_length));
    endproperty
    a_hold: assert property (p_hold) else $error("stalled result changed");
endmodule

// ===== hdl/bdll_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdll_datapath
// Node pool memories, free stack, head/tail/count and the list walker.
// ----------------------------------------------------------------------------
module bdll_datapath
    import bdll_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctl                          i_ctl,
    input  logic [2:0]                    i_operation,
    input  logic signed [31:0]            i_item_value,
    input  logic signed [31:0]            i_anchor_key,
    output t_sts                          o_sts,
    output logic [$clog2(CAPACITY+1)-1:0] o_count
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]   r_val_mem  [CAPACITY];
    logic [IW-1:0] r_prev_mem [CAPACITY];
    logic [IW-1:0] r_next_mem [CAPACITY];
    logic [IW-1:0] r_free_mem [CAPACITY];

    logic [31:0]   r_val, r_key;
    logic [2:0]    r_op;
    logic [IW-1:0] r_head, r_tail, r_pos, r_walk;
    logic [CW-1:0] r_count, r_free_top, r_steps, r_clr;
    logic          r_hit, r_clr_busy;
    logic [31:0]   r_rd_val;
    logic [IW-1:0] r_rd_next, r_rd_prev, r_free_rd;

    logic [31:0]   w_target;
    logic [IW-1:0] w_rd_addr;
    logic [IW-1:0] w_new;
    logic [CW-1:0] w_top_m1;

    assign w_target = (r_op == OP_INS_AFTER) ? r_key : r_val;
    assign w_top_m1 = r_free_top - CW'(1);
    assign w_new    = r_free_rd;

    // Read address: walker during search, the position node otherwise.
    always_comb begin
        case (i_ctl.cmd)
            UC_SRCH_START: w_rd_addr = r_head;
            UC_SRCH_STEP:  w_rd_addr = r_rd_next;
            UC_NOP:        w_rd_addr = r_walk;
            default:       w_rd_addr = r_pos;
        endcase
    end

    // Registered reads of the pools; free stack read tracks its top.
    always_ff @(posedge i_clk) begin
        r_rd_val  <= r_val_mem[w_rd_addr];
        r_rd_next <= r_next_mem[w_rd_addr];
        r_rd_prev <= r_prev_mem[w_rd_addr];
        r_free_rd <= r_free_mem[w_top_m1[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == UC_LOAD) begin
            r_op  <= i_operation;
            r_val <= i_item_value;
            r_key <= i_anchor_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_tail <= '0; r_count <= '0;
            r_free_top <= '0; r_clr <= '0; r_clr_busy <= 1'b1;
            r_steps <= '0; r_hit <= 1'b0; r_pos <= '0; r_walk <= '0;
        end else begin
            case (i_ctl.cmd)
                UC_LOAD: begin
                    r_hit <= 1'b0;
                    if (i_operation == OP_CLEAR) begin
                        r_clr <= '0; r_clr_busy <= 1'b1; r_free_top <= '0;
                        r_head <= '0; r_tail <= '0; r_count <= '0;
                    end
                end
                UC_CLEAR_STEP: begin
                    r_free_mem[r_clr[IW-1:0]] <= r_clr[IW-1:0];
                    r_clr      <= r_clr + CW'(1);
                    r_free_top <= r_clr + CW'(1);
                    if (r_clr == CW'(CAPACITY - 1)) r_clr_busy <= 1'b0;
                end
                UC_SRCH_START: begin
                    r_steps <= '0;
                    r_walk  <= r_head;
                end
                UC_SRCH_STEP: begin
                    if (r_rd_val == w_target) begin
                        r_hit <= 1'b1;
                        r_pos <= r_walk;
                    end
                    r_walk  <= r_rd_next;
                    r_steps <= r_steps + CW'(1);
                end
                UC_POS_HEAD: r_pos <= r_head;
                UC_POS_TAIL: r_pos <= r_tail;
                UC_INS_FRONT: begin
                    r_val_mem[w_new]  <= r_val;
                    r_next_mem[w_new] <= r_head;
                    if (r_count != '0) r_prev_mem[r_head] <= w_new;
                    else r_tail <= w_new;
                    r_head <= w_new;
                    r_count <= r_count + CW'(1);
                    r_free_top <= w_top_m1;
                end
                UC_INS_BACK: begin
                    r_val_mem[w_new]  <= r_val;
                    r_prev_mem[w_new] <= r_tail;
                    if (r_count != '0) r_next_mem[r_tail] <= w_new;
                    else r_head <= w_new;
                    r_tail <= w_new;
                    r_count <= r_count + CW'(1);
                    r_free_top <= w_top_m1;
                end
                UC_INS_AFTER: begin
                    // r_rd_next holds next link of the anchor node.
                    r_val_mem[w_new]  <= r_val;
                    r_prev_mem[w_new] <= r_pos;
                    r_next_mem[w_new] <= r_rd_next;
                    r_next_mem[r_pos] <= w_new;
                    if (r_pos == r_tail) r_tail <= w_new;
                    else r_prev_mem[r_rd_next] <= w_new;
                    r_count <= r_count + CW'(1);
                    r_free_top <= w_top_m1;
                end
                UC_UNLINK: begin
                    if (r_count <= CW'(1)) begin
                        r_head <= '0; r_tail <= '0;
                    end else if (r_pos == r_head) begin
                        r_head <= r_rd_next;
                    end else if (r_pos == r_tail) begin
                        r_tail <= r_rd_prev;
                    end else begin
                        r_next_mem[r_rd_prev] <= r_rd_next;
                        r_prev_mem[r_rd_next] <= r_rd_prev;
                    end
                    if (r_free_top < CW'(CAPACITY)) begin
                        r_free_mem[r_free_top[IW-1:0]] <= r_pos;
                        r_free_top <= r_free_top + CW'(1);
                    end
                    r_count <= r_count - CW'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_sts.full       = (r_free_top == '0) || (r_count >= CW'(CAPACITY));
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.srch_done  = r_hit || (r_steps >= r_count);
    assign o_sts.srch_hit   = r_hit;
    assign o_sts.clear_done = !r_clr_busy;
    assign o_sts.one_left   = (r_count == CW'(1));
    assign o_count          = r_count;

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CW'(CAPACITY);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("count over capacity");

    property p_pool_sum;
        @(posedge i_clk) disable iff (!i_rst_n)
            !r_clr_busy |-> (r_count + r_free_top == CW'(CAPACITY));
    endproperty
    a_pool_sum: assert property (p_pool_sum) else $error("pool accounting broken");

    property p_empty_ends;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_count == '0) |-> (r_head == '0 && r_tail == '0);
    endproperty
    a_empty_ends: assert property (p_empty_ends) else $error("empty list has ends");
endmodule

// ===== hdl/bdll_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdll_controller
// Sequences each operation into datapath micro-operations and signals when to
// load the result register.
// ----------------------------------------------------------------------------
module bdll_controller
    import bdll_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_operation,
    input  t_sts       i_sts,
    output t_ctl       o_ctl,
    output logic       o_res_load,
    output logic [1:0] o_res_status,
    output logic       o_res_found,
    input  logic       i_res_busy
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_SRCH_FETCH, S_SRCH_STEP,
        S_POS_WAIT, S_INS_AFTER, S_UNLINK, S_DONE
    } t_state;

    t_state     r_state, n_state;
    t_op        r_op;
    logic [1:0] r_status, n_status;
    logic       r_found, n_found;
    t_ctl       w_ctl;

    assign o_stall = (r_state != S_IDLE) || i_res_busy;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_found  = r_found;
        w_ctl.cmd = UC_NOP;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_done) begin
                    // A clear that came from an item reports once the sweep is done.
                    n_state = (r_op == OP_CLEAR) ? S_DONE : S_IDLE;
                end else begin
                    w_ctl.cmd = UC_CLEAR_STEP;
                end
            end
            S_IDLE: begin
                if (i_valid && !i_res_busy) begin
                    w_ctl.cmd = UC_LOAD;
                    n_state   = S_DISPATCH;
                    n_status  = ST_OK;
                    n_found   = 1'b0;
                end
            end
            S_DISPATCH: begin
                case (r_op)
                    OP_INS_FRONT: begin
                        if (i_sts.full) n_status = ST_FULL;
                        else w_ctl.cmd = UC_INS_FRONT;
                        n_state = S_DONE;
                    end
                    OP_INS_BACK: begin
                        if (i_sts.full) n_status = ST_FULL;
                        else w_ctl.cmd = UC_INS_BACK;
                        n_state = S_DONE;
                    end
                    OP_REM_FRONT, OP_REM_BACK: begin
                        if (i_sts.empty) begin
                            n_status = ST_EMPTY; n_state = S_DONE;
                        end else begin
                            w_ctl.cmd = (r_op == OP_REM_FRONT) ? UC_POS_HEAD : UC_POS_TAIL;
                            n_state = S_POS_WAIT;
                        end
                    end
                    OP_CLEAR: n_state = S_CLEAR;
                    default: begin
                        if (i_sts.empty && r_op != OP_INS_AFTER) begin
                            n_status = ST_EMPTY; n_state = S_DONE;
                        end else begin
                            w_ctl.cmd = UC_SRCH_START;
                            n_state = S_SRCH_FETCH;
                        end
                    end
                endcase
            end
            S_SRCH_FETCH: begin
                // Node data for the walker appears next cycle.
                n_state = S_SRCH_STEP;
            end
            S_SRCH_STEP: begin
                if (i_sts.srch_done) begin
                    n_found = i_sts.srch_hit;
                    case (r_op)
                        OP_INS_AFTER: begin
                            if (i_sts.full) begin
                                n_status = ST_FULL; n_state = S_DONE;
                            end else if (i_sts.srch_hit) begin
                                w_ctl.cmd = UC_RD_NEXT; n_state = S_INS_AFTER;
                            end else begin
                                w_ctl.cmd = UC_INS_BACK; n_state = S_DONE;
                            end
                        end
                        OP_REM_VALUE: begin
                            if (i_sts.srch_hit) begin
                                w_ctl.cmd = UC_RD_PREV; n_state = S_UNLINK;
                            end else begin
                                n_status = ST_NOTFOUND; n_state = S_DONE;
                            end
                        end
                        default: begin
                            if (!i_sts.srch_hit) n_status = ST_NOTFOUND;
                            n_state = S_DONE;
                        end
                    endcase
                end else begin
                    w_ctl.cmd = UC_SRCH_STEP;
                    n_state   = S_SRCH_FETCH;
                end
            end
            S_POS_WAIT: begin
                w_ctl.cmd = UC_RD_PREV;
                n_state   = S_UNLINK;
            end
            S_INS_AFTER: begin
                w_ctl.cmd = UC_INS_AFTER;
                n_state   = S_DONE;
            end
            S_UNLINK: begin
                w_ctl.cmd = UC_UNLINK;
                n_state   = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_op     <= OP_INS_FRONT;
            r_status <= ST_OK;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_found  <= n_found;
            if (w_ctl.cmd == UC_LOAD) r_op <= t_op'(i_operation);
        end
    end

    assign o_ctl        = w_ctl;
    assign o_res_load   = (r_state == S_DONE);
    assign o_res_status = r_status;
    assign o_res_found  = r_found;

    property p_done_idle;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state == S_DONE) |=> (r_state == S_IDLE);
    endproperty
    a_done_idle: assert property (p_done_idle) else $error("done not followed by idle");

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            (w_ctl.cmd == UC_LOAD) |-> (r_state == S_IDLE && !i_res_busy);
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("load while busy");

    property p_full_status;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_DISPATCH && r_op == OP_INS_FRONT && i_sts.full)
            |=> (r_status == ST_FULL);
    endproperty
    a_full_status: assert property (p_full_status) else $error("full not reported");
endmodule

// ===== tb/sv/tb_bounded_doubly_linked_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list engine testbench
// Drives list operations into the engine with random idle cycles on both
// sides. A behavioral list model predicts status, found flag and length.
// ----------------------------------------------------------------------------
module tb_bounded_doubly_linked_list_engine
    import bdll_pkg::*;
();

    localparam int CAP = 64;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [6:0] length;
    } t_result;

    // Scoreboard: the list contents in order, and the results still owed.
    class list_scoreboard;
        logic [31:0] contents[$];
        t_result     pending[$];
        int          n_errors;
        int          n_checked;

        function int locate(logic [31:0] v);
            foreach (contents[k]) begin
                if (contents[k] == v) return k;
            end
            return -1;
        endfunction

        function void note_item(t_op op, logic [31:0] v, logic [31:0] key);
            t_result r;
            int      at;
            r = '0;
            case (op)
                OP_INS_FRONT: begin
                    if (contents.size() >= CAP) r.status = ST_FULL;
                    else contents.push_front(v);
                end
                OP_INS_BACK: begin
                    if (contents.size() >= CAP) r.status = ST_FULL;
                    else contents.push_back(v);
                end
                OP_INS_AFTER: begin
                    at = locate(key);
                    r.found = (at >= 0);
                    if (contents.size() >= CAP) r.status = ST_FULL;
                    else if (at >= 0) contents.insert(at + 1, v);
                    else contents.push_back(v);
                end
                OP_REM_FRONT: begin
                    if (contents.size() == 0) r.status = ST_EMPTY;
                    else void'(contents.pop_front());
                end
                OP_REM_BACK: begin
                    if (contents.size() == 0) r.status = ST_EMPTY;
                    else void'(contents.pop_back());
                end
                OP_REM_VALUE, OP_FIND: begin
                    at = locate(v);
                    if (contents.size() == 0) r.status = ST_EMPTY;
                    else if (at < 0) r.status = ST_NOTFOUND;
                    else begin
                        r.found = 1'b1;
                        if (op == OP_REM_VALUE) contents.delete(at);
                    end
                end
                default: contents.delete();
            endcase
            r.length = 7'(contents.size());
            pending.push_back(r);
        endfunction

        task check_result(t_result got);
            t_result want;
            n_checked++;
            if (pending.size() == 0) begin
                report_error("result with nothing expected", got, got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) report_error("status", got, want);
            if (got.found !== want.found) report_error("found", got, want);
            if (got.length !== want.length) report_error("length", got, want);
        endtask

        task report_error(string what, t_result got, t_result want);
            n_errors++;
            $display("%0t mismatch %s: got st=%0d f=%0d len=%0d want st=%0d f=%0d len=%0d",
                     $time, what, got.status, got.found, got.length,
                     want.status, want.found, want.length);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_operation = '0;
    logic signed [31:0] i_item_value = '0;
    logic signed [31:0] i_anchor_key = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic        o_found;
    logic [6:0]  o_length;

    list_scoreboard sb;
    int  cycles = 0;
    bit  calm = 1'b0;
    int  n_sent = 0;
    logic [31:0] pool[8];

    always #5 i_clk = ~i_clk;

    bounded_doubly_linked_list_engine #(.CAPACITY(CAP)) DUT (.*);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_bounded_doubly_linked_list_engine: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_status, o_found, o_length});
        i_stall <= !calm && ($urandom_range(99) < 9);
    end

    // One transfer; valid stays high until the engine takes the item.
    task automatic send_item(t_op op, logic [31:0] v, logic [31:0] key);
        while (!calm && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_item_value <= v;
        i_anchor_key <= key;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(op, v, key);
        n_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(3) == 0) return $urandom;
        return pool[$urandom_range(7)];
    endfunction

    // Inserts a little under half the time while short, mostly removals when nearly full.
    function automatic t_op pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 1) return OP_CLEAR;
        if (sb.contents.size() > 56 && r < 60) return t_op'(3 + $urandom_range(2));
        if (r < 45) return t_op'($urandom_range(2));
        return t_op'(3 + $urandom_range(3));
    endfunction

    initial begin
        logic [31:0] v;
        sb = new();
        foreach (pool[k]) pool[k] = $urandom;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'hFFFF_FFFF;
        pool[3] = 32'h0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list cases, extremes, absent anchor, clear.
        send_item(OP_REM_FRONT, 0, 0);
        send_item(OP_REM_BACK, 0, 0);
        send_item(OP_REM_VALUE, 5, 0);
        send_item(OP_FIND, 5, 0);
        send_item(OP_INS_FRONT, 32'h8000_0000, 0);
        send_item(OP_INS_BACK, 32'h7FFF_FFFF, 0);
        send_item(OP_INS_AFTER, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(OP_INS_AFTER, 32'h0, 32'h1234_5678);
        send_item(OP_FIND, 32'hFFFF_FFFF, 0);
        send_item(OP_FIND, 32'h5555_5555, 0);
        send_item(OP_REM_VALUE, 32'h7FFF_FFFF, 0);
        send_item(OP_REM_VALUE, 32'h0, 0);
        send_item(OP_REM_FRONT, 0, 0);
        send_item(OP_REM_BACK, 0, 0);
        send_item(OP_REM_BACK, 0, 0);
        send_item(OP_CLEAR, 0, 0);
        // Fill the pool, then try every insert when full.
        for (int k = 0; k < CAP; k++) send_item(OP_INS_BACK, k, 0);
        send_item(OP_INS_FRONT, 1, 0);
        send_item(OP_INS_BACK, 1, 0);
        send_item(OP_INS_AFTER, 1, 3);
        send_item(OP_INS_AFTER, 1, 999);
        send_item(OP_FIND, CAP - 1, 0);
        send_item(OP_REM_VALUE, 20, 0);
        send_item(OP_CLEAR, 0, 0);

        for (int k = 0; k < 1400; k++) begin
            calm = (k >= 600 && k < 800);
            v = pick_value();
            send_item(pick_op(), v, pick_value());
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d list operations, checked %0d results, %0d cycles",
                 n_sent, sb.n_checked, cycles);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("tb_bounded_doubly_linked_list_engine: clean");
        else
            $display("tb_bounded_doubly_linked_list_engine: errors");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/bdll_pkg.sv
hdl/bdll_datapath.sv
hdl/bdll_controller.sv
hdl/bounded_doubly_linked_list_engine.sv
tb/sv/tb_bounded_doubly_linked_list_engine.sv
